FILE: rtl/core/tvs_pkg.sv
// Shared codes, register indexes and configuration types of the trilinear volume sampler.
package tvs_pkg;

  localparam int COORD_W     = 32;
  localparam int FRAC_W      = 16;
  localparam int RAW_W       = 16;
  localparam int VAL_W       = 32;
  localparam int INV_W       = 31;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [0:0] {
    FUNC_STORE  = 1'b0,
    FUNC_SAMPLE = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OUTSIDE  = 2'd1,
    ST_BAD_KIND = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    KIND_UNORM8  = 2'd0,
    KIND_UNORM16 = 2'd1,
    KIND_SNORM16 = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_GRID_DIMS = 3'd0,
    REG_KIND      = 3'd1,
    REG_ORIGIN_X  = 3'd2,
    REG_ORIGIN_Y  = 3'd3,
    REG_ORIGIN_Z  = 3'd4,
    REG_INV_X     = 3'd5,
    REG_INV_Y     = 3'd6,
    REG_INV_Z     = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [COORD_W-1:0] origin;
    logic [INV_W-1:0]   inv_spacing;
  } axis_cfg_t;

endpackage

FILE: rtl/core/tvs_front.sv
// Front pipeline: maps sample points to grid cells and classifies every transaction.
module tvs_front #(
  parameter int  DIM_BITS = 10,
  parameter type item_t   = logic
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  tvs_pkg::func_t                     in_func,
  input  logic [tvs_pkg::RAW_W-1:0]          in_index,
  input  logic [tvs_pkg::RAW_W-1:0]          in_raw,
  input  logic [2:0][tvs_pkg::COORD_W-1:0]   in_coord,
  input  logic [2:0][DIM_BITS-1:0]           dims,
  input  tvs_pkg::axis_cfg_t                 axis_cfg [3],
  input  tvs_pkg::kind_t                     kind,
  output logic                               out_valid,
  input  logic                               out_ready,
  output item_t                              out_item
);
  import tvs_pkg::*;

  localparam int PROD_W = COORD_W + INV_W;
  localparam int HI_W   = PROD_W - 32;

  logic                  adv;
  logic                  v1, v2;
  func_t                 func1, func2;
  logic [RAW_W-1:0]      idx1, idx2, raw1, raw2;
  logic [2:0]            neg1, neg2;
  logic [COORD_W-1:0]    mag1 [3];
  logic [PROD_W-1:0]     prod2 [3];
  item_t                 item_next;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      func1 <= in_func;
      idx1  <= in_index;
      raw1  <= in_raw;
      for (int k = 0; k < 3; k++) begin
        logic signed [COORD_W:0] diff;
        diff    = $signed({in_coord[k][COORD_W-1], in_coord[k]}) -
                  $signed({axis_cfg[k].origin[COORD_W-1], axis_cfg[k].origin});
        neg1[k] <= diff[COORD_W];
        mag1[k] <= diff[COORD_W] ? COORD_W'(-diff) : diff[COORD_W-1:0];
      end
      func2 <= func1;
      idx2  <= idx1;
      raw2  <= raw1;
      neg2  <= neg1;
      for (int k = 0; k < 3; k++) begin
        prod2[k] <= PROD_W'(mag1[k]) * PROD_W'(axis_cfg[k].inv_spacing);
      end
      out_item <= item_next;
    end
  end

  always_comb begin
    logic [2:0]          outside;
    logic [DIM_BITS-1:0] dim, dm1, i0;
    logic [DIM_BITS:0]   i0p1;
    logic [HI_W-1:0]     hi;
    logic [31:0]         lo32;
    logic                over, at_lim;
    item_next          = '0;
    item_next.func     = func2;
    item_next.st_index = idx2;
    item_next.st_raw   = raw2;
    for (int k = 0; k < 3; k++) begin
      dim    = dims[k];
      dm1    = dim - 1'b1;
      hi     = prod2[k][PROD_W-1:32];
      lo32   = prod2[k][31:0];
      over   = (hi > HI_W'(dm1)) || ((hi == HI_W'(dm1)) && (lo32 != '0));
      at_lim = (hi == HI_W'(dm1)) && (lo32 == '0);
      outside[k] = (dim == '0) || (neg2[k] && (prod2[k] != '0)) || over;
      if (dim == DIM_BITS'(1)) begin
        i0                = '0;
        item_next.frac[k] = '0;
      end else if (at_lim) begin
        i0                = dim - DIM_BITS'(2);
        item_next.frac[k] = '1;
      end else begin
        i0                = hi[DIM_BITS-1:0];
        item_next.frac[k] = lo32[31:16];
      end
      i0p1 = {1'b0, i0} + 1'b1;
      item_next.lo[k] = i0;
      item_next.hi[k] = (i0p1 < {1'b0, dim}) ? i0p1[DIM_BITS-1:0] : dm1;
    end
    if (func2 == FUNC_STORE) begin
      item_next.status = ST_OK;
    end else if (outside != '0) begin
      item_next.status = ST_OUTSIDE;
    end else if (kind == KIND_NONE) begin
      item_next.status = ST_BAD_KIND;
    end else begin
      item_next.status = ST_OK;
    end
  end

endmodule

FILE: rtl/core/tvs_queue.sv
// Short FIFO that decouples the front pipeline from the back pipeline.
module tvs_queue #(
  parameter type item_t = logic
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);
  import tvs_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  item_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign push_ready = count != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = slots[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_item;
    end
  end

endmodule

FILE: rtl/core/tvs_back.sv
// Back pipeline: voxel addressing, replicated voxel memory, conversion and trilinear blend.
module tvs_back #(
  parameter int  DIM_BITS   = 10,
  parameter int  MAX_VOXELS = 65536,
  parameter type item_t     = logic
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  item_t                          in_item,
  input  logic [2:0][DIM_BITS-1:0]       dims,
  input  tvs_pkg::kind_t                 kind,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tvs_pkg::VAL_W-1:0]      out_value,
  output tvs_pkg::status_t               out_status
);
  import tvs_pkg::*;

  localparam int ROW_W  = 2 * DIM_BITS;
  localparam int FULL_W = 3 * DIM_BITS;
  localparam int MW     = $clog2(MAX_VOXELS);
  localparam int NRED   = (FULL_W >= MW) ? FULL_W - MW + 1 : 0;
  localparam int RW     = FULL_W + 1;

  function automatic logic signed [VAL_W-1:0] conv(input kind_t k, input logic [RAW_W-1:0] raw);
    logic [14:0] w8;
    logic [8:0]  c8;
    logic [30:0] w16;
    logic [16:0] c16;
    logic [15:0] m;
    logic [30:0] ws;
    logic [16:0] cs;
    logic [1:0]  e;
    logic [31:0] mag;
    logic signed [VAL_W-1:0] q;
    q = '0;
    unique case (k)
      KIND_UNORM8: begin
        w8 = {1'b0, raw[7:0], 6'b0} + 15'd127;
        c8 = {2'b0, w8[14:8]} + {1'b0, w8[7:0]};
        q  = $signed(32'(raw[7:0]) * 32'd4210752 + 32'(w8[14:8]) + 32'(c8 >= 9'd255));
      end
      KIND_UNORM16: begin
        w16 = {1'b0, raw, 14'b0} + 31'd32767;
        c16 = {2'b0, w16[30:16]} + {1'b0, w16[15:0]};
        q   = $signed(32'({raw, 14'b0}) + 32'(w16[30:16]) + 32'(c16 >= 17'd65535));
      end
      KIND_SNORM16: begin
        m   = raw[15] ? 16'(-raw) : raw;
        ws  = {m, 15'b0} + 31'd16383;
        cs  = {1'b0, ws[30:15]} + {2'b0, ws[14:0]};
        e   = (cs >= 17'd65534) ? 2'd2 : ((cs >= 17'd32767) ? 2'd1 : 2'd0);
        mag = 32'({m, 15'b0}) + 32'(ws[30:15]) + 32'(e);
        q   = raw[15] ? $signed(-mag) : $signed(mag);
      end
      KIND_NONE: q = '0;
      default:   q = '0;
    endcase
    return q;
  endfunction

  function automatic logic signed [VAL_W-1:0] lerp(input logic signed [VAL_W-1:0] a,
                                                   input logic signed [VAL_W-1:0] b,
                                                   input logic [FRAC_W-1:0] f);
    logic signed [VAL_W:0]  d;
    logic signed [49:0]     p;
    logic signed [49:0]     t;
    d = 33'(b) - 33'(a);
    p = 50'(d) * 50'($signed({1'b0, f}));
    t = p + 50'sd32768;
    return VAL_W'(33'(a) + 33'(t >>> 16));
  endfunction

  logic                     adv;
  logic                     va, vm, vc, vx, vy;
  item_t                    item_a, item_m, item_c, item_x, item_y;
  logic [ROW_W-1:0]         row_a [4];
  logic [NRED:0]            vr;
  item_t                    red_item [NRED+1];
  logic [FULL_W-1:0]        red_addr [NRED+1][8];
  logic [RAW_W-1:0]         rdata [8];
  logic signed [VAL_W-1:0]  val_c [8];
  logic signed [VAL_W-1:0]  lx [4];
  logic signed [VAL_W-1:0]  ly [2];
  logic [MW-1:0]            st_addr;
  logic                     st_we;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vm        <= 1'b0;
      vc        <= 1'b0;
      vx        <= 1'b0;
      vy        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      va        <= in_valid;
      vm        <= vr[NRED];
      vc        <= vm;
      vx        <= vc;
      vy        <= vx;
      out_valid <= vy;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_a <= in_item;
      for (int j = 0; j < 4; j++) begin
        logic [DIM_BITS-1:0] y, z;
        y = j[0] ? in_item.hi[1] : in_item.lo[1];
        z = j[1] ? in_item.hi[2] : in_item.lo[2];
        row_a[j] <= ROW_W'(y) + ROW_W'(dims[1]) * ROW_W'(z);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vr <= '0;
    end else if (adv) begin
      vr[0] <= va;
      for (int s = 0; s < NRED; s++) begin
        vr[s+1] <= vr[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      red_item[0] <= item_a;
      for (int c = 0; c < 8; c++) begin
        logic [DIM_BITS-1:0] x;
        x = c[0] ? item_a.hi[0] : item_a.lo[0];
        red_addr[0][c] <= FULL_W'(x) + FULL_W'(dims[0]) * FULL_W'(row_a[c >> 1]);
      end
      for (int s = 0; s < NRED; s++) begin
        red_item[s+1] <= red_item[s];
        for (int c = 0; c < 8; c++) begin
          if ({1'b0, red_addr[s][c]} >= (RW'(MAX_VOXELS) << (NRED - 1 - s))) begin
            red_addr[s+1][c] <= FULL_W'({1'b0, red_addr[s][c]} -
                                        (RW'(MAX_VOXELS) << (NRED - 1 - s)));
          end else begin
            red_addr[s+1][c] <= red_addr[s][c];
          end
        end
      end
    end
  end

  assign st_addr = MW'(red_item[NRED].st_index);
  assign st_we   = vr[NRED] && (red_item[NRED].func == FUNC_STORE) &&
                   (32'(red_item[NRED].st_index) < 32'(MAX_VOXELS));

  for (genvar c = 0; c < 8; c++) begin : g_bank
    logic [RAW_W-1:0] mem [MAX_VOXELS];
    logic [RAW_W-1:0] rd;
    always_ff @(posedge clk) begin
      if (adv) begin
        if (st_we) begin
          mem[st_addr] <= red_item[NRED].st_raw;
        end
        rd <= mem[MW'(red_addr[NRED][c])];
      end
    end
    assign rdata[c] = rd;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_m <= red_item[NRED];
      item_c <= item_m;
      for (int c = 0; c < 8; c++) begin
        val_c[c] <= conv(kind, rdata[c]);
      end
      item_x <= item_c;
      for (int j = 0; j < 4; j++) begin
        lx[j] <= lerp(val_c[2*j], val_c[2*j+1], item_c.frac[0]);
      end
      item_y <= item_x;
      for (int j = 0; j < 2; j++) begin
        ly[j] <= lerp(lx[2*j], lx[2*j+1], item_x.frac[1]);
      end
      out_status <= item_y.status;
      if ((item_y.func == FUNC_SAMPLE) && (item_y.status == ST_OK)) begin
        out_value <= lerp(ly[0], ly[1], item_y.frac[2]);
      end else begin
        out_value <= '0;
      end
    end
  end

endmodule

FILE: rtl/core/trilinear_volume_sampler.sv
// Trilinear volume sampler top level: configuration registers, front, queue and back.
// Throughput is one transaction per cycle while the output is not stalled by m_axis_tready;
// eight replicated voxel memories serve the eight corners.
// Reset clears the configuration registers, valid bits and queue; voxel memory is not cleared.
module trilinear_volume_sampler #(
  parameter int  MAX_VOXELS = 65536,
  parameter int  DIM_BITS   = 10,
  localparam int CFG_W      = (3 * DIM_BITS > 32) ? 3 * DIM_BITS : 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [127:0]     s_axis_tdata,   // voxel_index, voxel_raw, coord_x, coord_y, coord_z
  input  logic [0:0]       s_axis_tuser,   // func
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // sample_value
  output logic [1:0]       m_axis_tuser,   // status
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);
  import tvs_pkg::*;

  typedef struct packed {
    func_t                              func;
    status_t                            status;
    logic [RAW_W-1:0]                   st_index;
    logic [RAW_W-1:0]                   st_raw;
    logic [2:0][DIM_BITS-1:0]           lo;
    logic [2:0][DIM_BITS-1:0]           hi;
    logic [2:0][FRAC_W-1:0]             frac;
  } item_t;

  logic [2:0][DIM_BITS-1:0] grid_dims;
  kind_t                    element_kind;
  axis_cfg_t                axis_cfg [3];
  logic                     fq_valid, fq_ready, qb_valid, qb_ready;
  item_t                    fq_item, qb_item;
  status_t                  status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_dims    <= '0;
      element_kind <= KIND_UNORM8;
      for (int k = 0; k < 3; k++) begin
        axis_cfg[k].origin      <= '0;
        axis_cfg[k].inv_spacing <= INV_W'(65536);
      end
    end else if (cfg_valid) begin
      unique case (reg_index_t'(cfg_index))
        REG_GRID_DIMS: grid_dims                <= cfg_data[3*DIM_BITS-1:0];
        REG_KIND:      element_kind             <= kind_t'(cfg_data[1:0]);
        REG_ORIGIN_X:  axis_cfg[0].origin       <= cfg_data[COORD_W-1:0];
        REG_ORIGIN_Y:  axis_cfg[1].origin       <= cfg_data[COORD_W-1:0];
        REG_ORIGIN_Z:  axis_cfg[2].origin       <= cfg_data[COORD_W-1:0];
        REG_INV_X:     axis_cfg[0].inv_spacing  <= cfg_data[INV_W-1:0];
        REG_INV_Y:     axis_cfg[1].inv_spacing  <= cfg_data[INV_W-1:0];
        REG_INV_Z:     axis_cfg[2].inv_spacing  <= cfg_data[INV_W-1:0];
        default: ;
      endcase
    end
  end

  tvs_front #(
    .DIM_BITS (DIM_BITS),
    .item_t   (item_t)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_func   (func_t'(s_axis_tuser[0])),
    .in_index  (s_axis_tdata[15:0]),
    .in_raw    (s_axis_tdata[31:16]),
    .in_coord  (s_axis_tdata[127:32]),
    .dims      (grid_dims),
    .axis_cfg  (axis_cfg),
    .kind      (element_kind),
    .out_valid (fq_valid),
    .out_ready (fq_ready),
    .out_item  (fq_item)
  );

  tvs_queue #(
    .item_t (item_t)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_item  (fq_item),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_item   (qb_item)
  );

  tvs_back #(
    .DIM_BITS   (DIM_BITS),
    .MAX_VOXELS (MAX_VOXELS),
    .item_t     (item_t)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (qb_valid),
    .in_ready   (qb_ready),
    .in_item    (qb_item),
    .dims       (grid_dims),
    .kind       (element_kind),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_value  (m_axis_tdata),
    .out_status (status)
  );

  assign m_axis_tuser = status;

endmodule
